/* sv/barrel_support_point_unit_defines.svh */
// assertion helpers for the barrel support point unit
`ifndef BARREL_SUPPORT_POINT_UNIT_DEFINES_SVH
`define BARREL_SUPPORT_POINT_UNIT_DEFINES_SVH

// same-cycle implication
`define BSP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BSP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/bsp_pkg.sv */
package bsp_pkg;

    localparam int CELLS      = 32;
    localparam int K_W        = $clog2(CELLS);
    localparam int NORM_STEPS = 6;
    localparam int DEPTH      = 1 + 1 + CELLS + 1 + NORM_STEPS + 1 + 1 + CELLS + 1 + CELLS
                                + 1 + 1 + CELLS;

    localparam logic [2:0] CFG_Y_LOW    = 3'd0;
    localparam logic [2:0] CFG_Y_HIGH   = 3'd1;
    localparam logic [2:0] CFG_R_VERT   = 3'd2;
    localparam logic [2:0] CFG_R_HOR    = 3'd3;
    localparam logic [2:0] CFG_RAD_BIAS = 3'd4;

    typedef struct packed {
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] dz;
        logic [31:0]        pr;
        logic [30:0]        av;
        logic [30:0]        bv;
        logic signed [31:0] sy;
        logic               nz;
        logic               negx;
        logic               negz;
    } side_t;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -34'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

/* sv/bsp_sqrt_cell.sv */
module bsp_sqrt_cell (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [bsp_pkg::K_W-1:0] k,
    input  logic [63:0]          rem_i,
    input  logic [31:0]          root_i,
    input  bsp_pkg::side_t       side_i,
    output logic [63:0]          rem_o,
    output logic [31:0]          root_o,
    output bsp_pkg::side_t       side_o
);
    import bsp_pkg::*;

    logic [64:0] trial;
    logic        fits;
    logic [63:0] rem_next;
    logic [31:0] root_next;
    logic [63:0] rem_reg;
    logic [31:0] root_reg;
    side_t       side_reg;

    always_comb begin
        trial     = ({33'd0, root_i} << (int'(k) + 1)) + (65'd1 << (2 * int'(k)));
        fits      = {1'b0, rem_i} >= trial;
        rem_next  = fits ? rem_i - trial[63:0] : rem_i;
        root_next = fits ? (root_i | (32'd1 << k)) : root_i;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= side_i;
        end
    end

    assign rem_o  = rem_reg;
    assign root_o = root_reg;
    assign side_o = side_reg;
endmodule

/* sv/bsp_sqrt_chain.sv */
module bsp_sqrt_chain (
    input  logic           aclk,
    input  logic           en,
    input  logic [63:0]    rad_i,
    input  bsp_pkg::side_t side_i,
    output logic [31:0]    root_o,
    output bsp_pkg::side_t side_o
);
    import bsp_pkg::*;

    logic [63:0] rem_w  [0:CELLS];
    logic [31:0] root_w [0:CELLS];
    side_t       side_w [0:CELLS];

    assign rem_w[0]  = rad_i;
    assign root_w[0] = '0;
    assign side_w[0] = side_i;

    for (genvar i = 0; i < CELLS; i++) begin : g_cell
        bsp_sqrt_cell u_cell (
            .aclk   (aclk),
            .en     (en),
            .k      (K_W'(CELLS - 1 - i)),
            .rem_i  (rem_w[i]),
            .root_i (root_w[i]),
            .side_i (side_w[i]),
            .rem_o  (rem_w[i+1]),
            .root_o (root_w[i+1]),
            .side_o (side_w[i+1])
        );
    end

    assign root_o = root_w[CELLS];
    assign side_o = side_w[CELLS];
endmodule

/* sv/bsp_div_cell.sv */
module bsp_div_cell (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [bsp_pkg::K_W-1:0] k,
    input  logic [63:0]          rem0_i,
    input  logic [63:0]          rem1_i,
    input  logic [31:0]          q0_i,
    input  logic [31:0]          q1_i,
    input  logic [31:0]          den_i,
    input  bsp_pkg::side_t       side_i,
    output logic [63:0]          rem0_o,
    output logic [63:0]          rem1_o,
    output logic [31:0]          q0_o,
    output logic [31:0]          q1_o,
    output logic [31:0]          den_o,
    output bsp_pkg::side_t       side_o
);
    import bsp_pkg::*;

    logic [63:0] trial;
    logic        fit0;
    logic        fit1;
    logic [63:0] rem0_reg;
    logic [63:0] rem1_reg;
    logic [31:0] q0_reg;
    logic [31:0] q1_reg;
    logic [31:0] den_reg;
    side_t       side_reg;

    always_comb begin
        trial = {32'd0, den_i} << k;
        fit0  = rem0_i >= trial;
        fit1  = rem1_i >= trial;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem0_reg <= fit0 ? rem0_i - trial : rem0_i;
            rem1_reg <= fit1 ? rem1_i - trial : rem1_i;
            q0_reg   <= fit0 ? (q0_i | (32'd1 << k)) : q0_i;
            q1_reg   <= fit1 ? (q1_i | (32'd1 << k)) : q1_i;
            den_reg  <= den_i;
            side_reg <= side_i;
        end
    end

    assign rem0_o = rem0_reg;
    assign rem1_o = rem1_reg;
    assign q0_o   = q0_reg;
    assign q1_o   = q1_reg;
    assign den_o  = den_reg;
    assign side_o = side_reg;
endmodule

/* sv/bsp_div_chain.sv */
module bsp_div_chain (
    input  logic           aclk,
    input  logic           en,
    input  logic [63:0]    num0_i,
    input  logic [63:0]    num1_i,
    input  logic [31:0]    den_i,
    input  bsp_pkg::side_t side_i,
    output logic [31:0]    q0_o,
    output logic [31:0]    q1_o,
    output bsp_pkg::side_t side_o
);
    import bsp_pkg::*;

    logic [63:0] rem0_w [0:CELLS];
    logic [63:0] rem1_w [0:CELLS];
    logic [31:0] q0_w   [0:CELLS];
    logic [31:0] q1_w   [0:CELLS];
    logic [31:0] den_w  [0:CELLS];
    side_t       side_w [0:CELLS];

    assign rem0_w[0] = num0_i;
    assign rem1_w[0] = num1_i;
    assign q0_w[0]   = '0;
    assign q1_w[0]   = '0;
    assign den_w[0]  = den_i;
    assign side_w[0] = side_i;

    for (genvar i = 0; i < CELLS; i++) begin : g_cell
        bsp_div_cell u_cell (
            .aclk   (aclk),
            .en     (en),
            .k      (K_W'(CELLS - 1 - i)),
            .rem0_i (rem0_w[i]),
            .rem1_i (rem1_w[i]),
            .q0_i   (q0_w[i]),
            .q1_i   (q1_w[i]),
            .den_i  (den_w[i]),
            .side_i (side_w[i]),
            .rem0_o (rem0_w[i+1]),
            .rem1_o (rem1_w[i+1]),
            .q0_o   (q0_w[i+1]),
            .q1_o   (q1_w[i+1]),
            .den_o  (den_w[i+1]),
            .side_o (side_w[i+1])
        );
    end

    assign q0_o   = q0_w[CELLS];
    assign q1_o   = q1_w[CELLS];
    assign side_o = side_w[CELLS];
endmodule

/* sv/barrel_support_point_unit.sv */
// barrel support point unit
//
// input channel s_valid/s_ready carries a direction (s_dir_x, s_dir_y, s_dir_z), Q16.16.
// result channel m_valid/m_ready carries the support point (m_sup_x, m_sup_y, m_sup_z)
// and m_degenerate, set when the direction has no radial part (x and z are then zero).
// shape registers (index 0 y_low, 1 y_high, 2 r_vert, 3 r_hor, 4 radial bias) are written through
// cfg_we/cfg_index/cfg_wdata; the user must write them while no item is in flight (not enforced).
//
// one item per cycle is taken while s_ready is high; the pipeline is
// a chain of cells: 32 cells for the radial root, 32 for the angle norm root,
// 32 for the sin/cos divides, 32 for the final x/z divides, plus 15 single stages.
// the disc radii are produced by free-running cell chains from the registers and
// settle again after a register write.
//
// reset (aresetn low, synchronous) empties the pipeline and loads the default shape.
// when the receiver stalls, the result is held in the output register and the chain
// keeps moving as long as its last cell holds no item; otherwise s_ready drops.
`include "barrel_support_point_unit_defines.svh"

module barrel_support_point_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_dir_x,
    input  logic signed [31:0] s_dir_y,
    input  logic signed [31:0] s_dir_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_sup_x,
    output logic signed [31:0] m_sup_y,
    output logic signed [31:0] m_sup_z,
    output logic               m_degenerate
);
    import bsp_pkg::*;

    // shape registers
    logic signed [31:0] y_low_reg;
    logic signed [31:0] y_high_reg;
    logic [30:0]        r_vert_reg;
    logic [30:0]        r_hor_reg;
    logic signed [31:0] rad_bias_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            y_low_reg    <= -32'sd32768;
            y_high_reg   <= 32'sd32768;
            r_vert_reg   <= 31'd65536;
            r_hor_reg    <= 31'd65536;
            rad_bias_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_Y_LOW:    y_low_reg    <= cfg_wdata;
                CFG_Y_HIGH:   y_high_reg   <= cfg_wdata;
                CFG_R_VERT:   r_vert_reg   <= cfg_wdata[30:0];
                CFG_R_HOR:    r_hor_reg    <= cfg_wdata[30:0];
                CFG_RAD_BIAS: rad_bias_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // flow control
    logic             m_valid_reg;
    logic [DEPTH-1:0] vld_reg;
    logic             last_valid;
    logic             out_load;
    logic             en;

    assign last_valid = vld_reg[DEPTH-1];
    assign out_load   = !m_valid_reg || m_ready;
    assign en         = out_load || !last_valid;
    assign s_ready    = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en) begin
                vld_reg <= {vld_reg[DEPTH-2:0], s_valid};
            end
            if (out_load) begin
                m_valid_reg <= last_valid;
            end
        end
    end

    // disc radii from the registers, free running
    logic [63:0]        ds_rv2_reg;
    logic [63:0]        ds_hh_reg;
    logic [63:0]        ds_hl_reg;
    logic [63:0]        ds_radh_reg;
    logic [63:0]        ds_radl_reg;
    logic [31:0]        ds_qh;
    logic [31:0]        ds_ql;
    logic [63:0]        ds_ph_reg;
    logic [63:0]        ds_pl_reg;
    logic [31:0]        ds_eh;
    logic [31:0]        ds_el;
    logic signed [31:0] ds_rh_reg;
    logic signed [31:0] ds_rl_reg;

    always_ff @(posedge aclk) begin
        ds_rv2_reg  <= 64'(r_vert_reg) * 64'(r_vert_reg);
        ds_hh_reg   <= 64'(mag32(y_high_reg)) * 64'(mag32(y_high_reg));
        ds_hl_reg   <= 64'(mag32(y_low_reg)) * 64'(mag32(y_low_reg));
        ds_radh_reg <= ds_rv2_reg - ds_hh_reg;
        ds_radl_reg <= ds_rv2_reg - ds_hl_reg;
        ds_ph_reg   <= 64'(r_hor_reg) * 64'(ds_qh);
        ds_pl_reg   <= 64'(r_hor_reg) * 64'(ds_ql);
        ds_rh_reg   <= sat32({2'b00, ds_eh} + {{2{rad_bias_reg[31]}}, rad_bias_reg});
        ds_rl_reg   <= sat32({2'b00, ds_el} + {{2{rad_bias_reg[31]}}, rad_bias_reg});
    end

    bsp_sqrt_chain u_disc_root_h (
        .aclk   (aclk),
        .en     (1'b1),
        .rad_i  (ds_radh_reg),
        .side_i ('0),
        .root_o (ds_qh),
        .side_o ()
    );

    bsp_sqrt_chain u_disc_root_l (
        .aclk   (aclk),
        .en     (1'b1),
        .rad_i  (ds_radl_reg),
        .side_i ('0),
        .root_o (ds_ql),
        .side_o ()
    );

    bsp_div_chain u_disc_div (
        .aclk   (aclk),
        .en     (1'b1),
        .num0_i (ds_ph_reg),
        .num1_i (ds_pl_reg),
        .den_i  ({1'b0, r_vert_reg}),
        .side_i ('0),
        .q0_o   (ds_eh),
        .q1_o   (ds_el),
        .side_o ()
    );

    // squares of the radial components
    side_t       a_side_next;
    side_t       a_side_reg;
    logic [63:0] a_sqx_reg;
    logic [63:0] a_sqz_reg;
    side_t       b_side_reg;
    logic [63:0] b_rad_reg;

    always_comb begin
        a_side_next    = '0;
        a_side_next.dx = s_dir_x;
        a_side_next.dy = s_dir_y;
        a_side_next.dz = s_dir_z;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_side_reg <= a_side_next;
            a_sqx_reg  <= 64'(mag32(s_dir_x)) * 64'(mag32(s_dir_x));
            a_sqz_reg  <= 64'(mag32(s_dir_z)) * 64'(mag32(s_dir_z));
            b_side_reg <= a_side_reg;
            b_rad_reg  <= a_sqx_reg + a_sqz_reg;
        end
    end

    logic [31:0] c_root;
    side_t       c_side;

    bsp_sqrt_chain u_radial_root (
        .aclk   (aclk),
        .en     (en),
        .rad_i  (b_rad_reg),
        .side_i (b_side_reg),
        .root_o (c_root),
        .side_o (c_side)
    );

    // angle terms and their normalization
    logic [62:0]           norm_a_reg    [0:NORM_STEPS];
    logic [62:0]           norm_b_reg    [0:NORM_STEPS];
    side_t                 norm_side_reg [0:NORM_STEPS];
    side_t                 norm_side_next;
    logic [NORM_STEPS-1:0] norm_big;

    always_comb begin
        norm_side_next    = c_side;
        norm_side_next.pr = c_root;
        for (int j = 0; j < NORM_STEPS; j++) begin
            norm_big[j] = |((norm_a_reg[j] | norm_b_reg[j])
                            >> (30 + ((1 << (NORM_STEPS - 1)) >> j)));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            norm_a_reg[0]    <= 63'(mag32(c_side.dy)) * 63'(r_vert_reg);
            norm_b_reg[0]    <= 63'(c_root) * 63'(r_hor_reg);
            norm_side_reg[0] <= norm_side_next;
            for (int j = 0; j < NORM_STEPS; j++) begin
                norm_a_reg[j+1]    <= norm_big[j]
                                      ? norm_a_reg[j] >> ((1 << (NORM_STEPS - 1)) >> j)
                                      : norm_a_reg[j];
                norm_b_reg[j+1]    <= norm_big[j]
                                      ? norm_b_reg[j] >> ((1 << (NORM_STEPS - 1)) >> j)
                                      : norm_b_reg[j];
                norm_side_reg[j+1] <= norm_side_reg[j];
            end
        end
    end

    side_t       f_side_next;
    side_t       f_side_reg;
    logic [61:0] f_aa_reg;
    logic [61:0] f_bb_reg;
    side_t       g_side_reg;
    logic [63:0] g_sum_reg;

    always_comb begin
        f_side_next    = norm_side_reg[NORM_STEPS];
        f_side_next.av = norm_a_reg[NORM_STEPS][30:0];
        f_side_next.bv = norm_b_reg[NORM_STEPS][30:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_side_reg <= f_side_next;
            f_aa_reg   <= 62'(norm_a_reg[NORM_STEPS][30:0])
                          * 62'(norm_a_reg[NORM_STEPS][30:0]);
            f_bb_reg   <= 62'(norm_b_reg[NORM_STEPS][30:0])
                          * 62'(norm_b_reg[NORM_STEPS][30:0]);
            g_side_reg <= f_side_reg;
            g_sum_reg  <= 64'(f_aa_reg) + 64'(f_bb_reg);
        end
    end

    logic [31:0] h_root;
    side_t       h_side;

    bsp_sqrt_chain u_norm_root (
        .aclk   (aclk),
        .en     (en),
        .rad_i  (g_sum_reg),
        .side_i (g_side_reg),
        .root_o (h_root),
        .side_o (h_side)
    );

    side_t       i_side_next;
    side_t       i_side_reg;
    logic [63:0] i_na_reg;
    logic [63:0] i_nb_reg;
    logic [31:0] i_den_reg;

    always_comb begin
        i_side_next    = h_side;
        i_side_next.nz = h_root == '0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            i_side_reg <= i_side_next;
            i_na_reg   <= 64'(r_vert_reg) * 64'(h_side.av);
            i_nb_reg   <= 64'(r_hor_reg) * 64'(h_side.bv);
            i_den_reg  <= h_root;
        end
    end

    logic [31:0] j_ys;
    logic [31:0] j_sh;
    side_t       j_side;

    bsp_div_chain u_angle_div (
        .aclk   (aclk),
        .en     (en),
        .num0_i (i_na_reg),
        .num1_i (i_nb_reg),
        .den_i  (i_den_reg),
        .side_i (i_side_reg),
        .q0_o   (j_ys),
        .q1_o   (j_sh),
        .side_o (j_side)
    );

    // surface point, then the top and bottom disc cuts
    logic               k_deg;
    logic signed [31:0] rv_s;
    logic signed [31:0] sy0;
    logic signed [31:0] sy1;
    logic signed [31:0] sy2;
    logic [31:0]        sh_eff;
    logic signed [31:0] sr;
    logic signed [31:0] rad1;
    logic signed [31:0] rad2;
    logic               top_hit;
    logic               bot_hit;
    side_t              k_side_next;

    always_comb begin
        k_deg = j_side.pr == '0;
        rv_s  = $signed({1'b0, r_vert_reg});
        if (k_deg) begin
            if (j_side.dy > 0) begin
                sy0 = rv_s;
            end else if (j_side.dy < 0) begin
                sy0 = -rv_s;
            end else begin
                sy0 = '0;
            end
        end else if (j_side.nz) begin
            sy0 = '0;
        end else begin
            sy0 = j_side.dy[31] ? -$signed(j_ys) : $signed(j_ys);
        end
        // zero angle norm gives zero ellipse radius
        sh_eff  = j_side.nz ? '0 : j_sh;
        sr      = sat32({2'b00, sh_eff} + {{2{rad_bias_reg[31]}}, rad_bias_reg});
        top_hit = (mag32(y_high_reg) < {1'b0, r_vert_reg}) && (sy0 > y_high_reg);
        sy1     = top_hit ? y_high_reg : sy0;
        rad1    = top_hit ? ds_rh_reg : sr;
        bot_hit = (mag32(y_low_reg) < {1'b0, r_vert_reg}) && (sy1 < y_low_reg);
        sy2     = bot_hit ? y_low_reg : sy1;
        rad2    = bot_hit ? ds_rl_reg : rad1;
        k_side_next    = j_side;
        k_side_next.sy = sy2;
    end

    side_t              k_side_reg;
    logic signed [31:0] k_rad_reg;
    side_t              l_side_next;
    side_t              l_side_reg;
    logic [63:0]        l_px_reg;
    logic [63:0]        l_pz_reg;

    always_comb begin
        l_side_next      = k_side_reg;
        l_side_next.negx = k_side_reg.dx[31] ^ k_rad_reg[31];
        l_side_next.negz = k_side_reg.dz[31] ^ k_rad_reg[31];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            k_side_reg <= k_side_next;
            k_rad_reg  <= rad2;
            l_side_reg <= l_side_next;
            l_px_reg   <= 64'(mag32(k_side_reg.dx)) * 64'(mag32(k_rad_reg));
            l_pz_reg   <= 64'(mag32(k_side_reg.dz)) * 64'(mag32(k_rad_reg));
        end
    end

    logic [31:0] m_qx;
    logic [31:0] m_qz;
    side_t       m_side;

    bsp_div_chain u_scale_div (
        .aclk   (aclk),
        .en     (en),
        .num0_i (l_px_reg),
        .num1_i (l_pz_reg),
        .den_i  (l_side_reg.pr),
        .side_i (l_side_reg),
        .q0_o   (m_qx),
        .q1_o   (m_qz),
        .side_o (m_side)
    );

    // output register
    logic               out_deg;
    logic signed [31:0] out_x;
    logic signed [31:0] out_z;
    logic signed [31:0] m_sup_x_reg;
    logic signed [31:0] m_sup_y_reg;
    logic signed [31:0] m_sup_z_reg;
    logic               m_degenerate_reg;

    always_comb begin
        out_deg = m_side.pr == '0;
        out_x   = sat32(m_side.negx ? -{2'b00, m_qx} : {2'b00, m_qx});
        out_z   = sat32(m_side.negz ? -{2'b00, m_qz} : {2'b00, m_qz});
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_sup_x_reg      <= out_deg ? '0 : out_x;
            m_sup_y_reg      <= m_side.sy;
            m_sup_z_reg      <= out_deg ? '0 : out_z;
            m_degenerate_reg <= out_deg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_sup_x      = m_sup_x_reg;
    assign m_sup_y      = m_sup_y_reg;
    assign m_sup_z      = m_sup_z_reg;
    assign m_degenerate = m_degenerate_reg;

    `BSP_ASSERT_IMP(a_ready_when_free, aclk, aresetn, !m_valid_reg, s_ready, "ready low with empty output")
    `BSP_ASSERT_NXT(a_item_enters, aclk, aresetn, s_valid && s_ready, vld_reg[0], "accepted item lost at entry")
    `BSP_ASSERT_IMP(a_degen_zero_xz, aclk, aresetn, m_valid && m_degenerate, (m_sup_x == 0) && (m_sup_z == 0), "degenerate item with nonzero x or z")
endmodule

/* sim/bsp_checker.sv */
module bsp_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_wdata,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [31:0] s_dir_x,
    input  logic signed [31:0] s_dir_y,
    input  logic signed [31:0] s_dir_z,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [31:0] m_sup_x,
    input  logic signed [31:0] m_sup_y,
    input  logic signed [31:0] m_sup_z,
    input  logic               m_degenerate,
    output int                 errors,
    output int                 pending,
    output int                 checked,
    output int                 degen_seen
);
    import bsp_pkg::*;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               degen;
    } support_t;

    support_t support_q[$];

    longint shp_y_low, shp_y_high, shp_r_vert, shp_r_hor, shp_rad_bias;

    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] bit_v;
        r = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > v) bit_v = bit_v >> 2;
        while (bit_v != 0) begin
            if (v >= r + bit_v) begin
                v = v - (r + bit_v);
                r = (r >> 1) + bit_v;
            end else begin
                r = r >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] umag(input longint v);
        logic [63:0] m;
        m = v < 0 ? -v : v;
        return m;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint dir_scale(input longint c, input longint r,
                                         input logic [63:0] pr);
        logic [63:0] q;
        longint v;
        q = (umag(c) * umag(r)) / pr;
        v = (q > 64'd2147483648) ? 64'sd2147483648 : longint'(q);
        return clamp32(((c < 0) != (r < 0)) ? -v : v);
    endfunction

    function automatic longint cap_radius(input longint h);
        logic [63:0] rv, hh, q, e;
        rv = shp_r_vert;
        hh = umag(h);
        q = isqrt(rv * rv - hh * hh);
        e = ($unsigned(shp_r_hor) * q) / rv;
        return clamp32(longint'(e) + shp_rad_bias);
    endfunction

    function automatic support_t support_of(input longint dx, input longint dy,
                                            input longint dz);
        support_t res;
        logic [63:0] pr, a, b, n, rv, rh;
        longint sx, sy, sz, ys, sh, sr, rc;
        logic degen;
        rv = shp_r_vert;
        rh = shp_r_hor;
        sx = 0;
        sz = 0;
        pr = isqrt(umag(dx) * umag(dx) + umag(dz) * umag(dz));
        degen = (pr == 0);
        if (degen) begin
            sy = dy > 0 ? shp_r_vert : (dy < 0 ? -shp_r_vert : 0);
        end else begin
            a = umag(dy) * rv;
            b = pr * rh;
            sh = 0;
            while (((a | b) >> 31) != 0) begin
                a = a >> 1;
                b = b >> 1;
            end
            n = isqrt(a * a + b * b);
            if (n != 0) begin
                ys = longint'((rv * a) / n);
                sy = dy < 0 ? -ys : ys;
                sh = longint'((rh * b) / n);
            end else begin
                sy = 0;
            end
            sr = clamp32(sh + shp_rad_bias);
            sx = dir_scale(dx, sr, pr);
            sz = dir_scale(dz, sr, pr);
        end
        if (umag(shp_y_high) < rv && sy > shp_y_high) begin
            sy = shp_y_high;
            if (!degen) begin
                rc = cap_radius(shp_y_high);
                sx = dir_scale(dx, rc, pr);
                sz = dir_scale(dz, rc, pr);
            end
        end
        if (umag(shp_y_low) < rv && sy < shp_y_low) begin
            sy = shp_y_low;
            if (!degen) begin
                rc = cap_radius(shp_y_low);
                sx = dir_scale(dx, rc, pr);
                sz = dir_scale(dz, rc, pr);
            end
        end
        res.x = sx[31:0];
        res.y = sy[31:0];
        res.z = sz[31:0];
        res.degen = degen;
        return res;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d (item %0d)", what, got, want, checked);
        errors++;
    endtask

    initial begin
        errors = 0;
        pending = 0;
        checked = 0;
        degen_seen = 0;
    end

    always @(posedge aclk) begin
        support_t want;
        if (!aresetn) begin
            shp_y_low = -32768;
            shp_y_high = 32768;
            shp_r_vert = 65536;
            shp_r_hor = 65536;
            shp_rad_bias = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_Y_LOW:    shp_y_low = longint'(signed'(cfg_wdata));
                    CFG_Y_HIGH:   shp_y_high = longint'(signed'(cfg_wdata));
                    CFG_R_VERT:   shp_r_vert = longint'({33'd0, cfg_wdata[30:0]});
                    CFG_R_HOR:    shp_r_hor = longint'({33'd0, cfg_wdata[30:0]});
                    CFG_RAD_BIAS: shp_rad_bias = longint'(signed'(cfg_wdata));
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (support_q.size() == 0) begin
                    report("unexpected item", m_sup_x, 0);
                end else begin
                    want = support_q.pop_front();
                    pending--;
                    checked++;
                    if (m_degenerate) degen_seen++;
                    if (m_sup_x !== want.x) report("sup_x", m_sup_x, want.x);
                    if (m_sup_y !== want.y) report("sup_y", m_sup_y, want.y);
                    if (m_sup_z !== want.z) report("sup_z", m_sup_z, want.z);
                    if (m_degenerate !== want.degen)
                        report("degenerate", m_degenerate, want.degen);
                end
            end
            if (s_valid && s_ready) begin
                support_q.push_back(support_of(s_dir_x, s_dir_y, s_dir_z));
                pending++;
            end
        end
    end

endmodule

/* sim/tb_top.sv */
module tb_top;
    import bsp_pkg::*;

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_wdata;
    logic               s_valid;
    logic               s_ready;
    logic signed [31:0] s_dir_x;
    logic signed [31:0] s_dir_y;
    logic signed [31:0] s_dir_z;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_sup_x;
    logic signed [31:0] m_sup_y;
    logic signed [31:0] m_sup_z;
    logic               m_degenerate;

    int errors, pending, checked, degen_seen;
    int idle_pct, stall_pct;

    barrel_support_point_unit u_top (.*);

    bsp_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #4000000;
        $display("timeout");
        $display("Regression FAIL");
        $finish;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    task automatic drain();
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic set_shape(input logic [31:0] ylo, input logic [31:0] yhi,
                             input logic [31:0] rv, input logic [31:0] rh,
                             input logic [31:0] off);
        drain();
        cfg_write(CFG_Y_LOW, ylo);
        cfg_write(CFG_Y_HIGH, yhi);
        cfg_write(CFG_R_VERT, rv);
        cfg_write(CFG_R_HOR, rh);
        cfg_write(CFG_RAD_BIAS, off);
        // index past the register list is ignored
        cfg_write(CFG_RAD_BIAS + 3'd1, $urandom);
        cfg_we <= 1'b0;
        // disc radius chain settles after a write
        repeat (100) @(posedge aclk);
    endtask

    task automatic send_dir(input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z);
        s_valid <= 1'b1;
        s_dir_x <= x;
        s_dir_y <= y;
        s_dir_z <= z;
        do @(posedge aclk); while (!s_ready);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            2, 3:    return $urandom_range(0, 1) ? $urandom_range(0, 1 << 20)
                                                 : -$urandom_range(0, 1 << 20);
            default: return $urandom;
        endcase
    endfunction

    task automatic rand_dirs(input int cnt, input bit pause_mid);
        logic [31:0] x, y, z;
        for (int i = 0; i < cnt; i++) begin
            x = rand_comp();
            y = rand_comp();
            z = rand_comp();
            if ($urandom_range(0, 9) == 0) begin
                x = 0;
                z = 0;
            end
            send_dir(x, y, z);
            if (pause_mid && i == cnt / 2) begin
                s_valid <= 1'b0;
                @(posedge aclk);
                drain();
            end
        end
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_height(input logic [31:0] rv);
        logic [31:0] h;
        h = $urandom_range(0, rv[30:0]);
        if ($urandom_range(0, 4) == 0) h = $urandom;
        return $urandom_range(0, 1) ? h : -h;
    endfunction

    initial begin
        logic [31:0] rv;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_dir_x = '0;
        s_dir_y = '0;
        s_dir_z = '0;
        m_ready = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (100) @(posedge aclk);

        // directed, default shape
        send_dir(0, 0, 0);
        send_dir(0, 32'h00010000, 0);
        send_dir(0, 32'hFFFF0000, 0);
        send_dir(0, 32'h7FFFFFFF, 0);
        send_dir(32'h00010000, 0, 0);
        send_dir(0, 0, 32'hFFFFFFFF);
        send_dir(32'h00010000, 32'h00010000, 32'h00010000);
        send_dir(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_dir(32'h80000000, 32'h80000000, 32'h80000000);
        send_dir(32'h80000000, 32'h7FFFFFFF, 0);
        send_dir(1, 32'h80000000, 1);
        send_dir(32'hFFFFFFFF, 32'h00001000, 32'h7FFFFFFF);
        s_valid <= 1'b0;
        @(posedge aclk);

        // extreme shapes
        set_shape(32'h80000000, 32'h7FFFFFFF, 1, 1, 0);
        send_dir(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000);
        send_dir(1, 0, 0);
        send_dir(0, 1, 0);
        send_dir(32'h80000000, 32'hFFFFFFFF, 1);
        s_valid <= 1'b0;
        @(posedge aclk);
        set_shape(32'h80000002, 32'h7FFFFFFE, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_dir(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_dir(32'h80000000, 32'h80000000, 32'h80000000);
        send_dir(0, 32'h80000000, 0);
        send_dir(5, 32'h7FFFFFFF, 32'hFFFFFFFB);
        s_valid <= 1'b0;
        @(posedge aclk);
        // zero horizontal axis gives a zero angle norm with no y component
        set_shape(32'hFFFF8000, 32'h00008000, 32'h80010000, 32'h80000000, 32'h80000000);
        send_dir(32'h00010000, 0, 32'h00010000);
        send_dir(32'h00010000, 32'h00010000, 0);
        send_dir(0, 0, 0);
        send_dir(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        s_valid <= 1'b0;
        @(posedge aclk);

        // random shapes and directions under each idling mix
        for (int p = 0; p < 8; p++) begin
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 62; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 62; end
                default: begin idle_pct = 31; stall_pct = 31; end
            endcase
            rv = (p == 7) ? 32'h7FFFFFFF : $urandom_range(1, 1 << (10 + 2 * p));
            set_shape(rand_height(rv), rand_height(rv), rv | ($urandom & 32'h80000000),
                      $urandom_range(1, 1 << (10 + 2 * p)),
                      $urandom_range(0, 1) ? -$urandom_range(0, rv) : $urandom_range(0, 1 << 18));
            rand_dirs(76, p == 2);
        end

        drain();
        repeat (300) @(posedge aclk);
        $display("%0d support points checked, %0d degenerate, over extreme and random shapes",
                 checked, degen_seen);
        $display("idling mixes: none, sender 62%%, receiver 62%%, both 31%%");
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
